// ===== rtl/mfd_pkg.sv =====
// ----------------------------------------------------------------------------
// mfd_pkg: shared types and constants for the marker frame deframer
// Marker patterns, matcher step functions, result codes, queue entry type.
// ----------------------------------------------------------------------------
`default_nettype none

package mfd_pkg;

   localparam int TAG_DIGITS_DEFAULT = 20;
   localparam int HOLD_DEPTH         = 6;
   localparam int START_LEN          = 9;
   localparam int END_LEN            = 7;

   localparam int START_PROG_W = 4;
   localparam int END_PROG_W   = 3;
   localparam int FILL_W       = 3;
   localparam int FRAME_W      = 16;
   localparam int TAG_W        = 64;

   localparam logic [FRAME_W-1:0] MAX_FRAME_RESET = 16'd4096;
   localparam logic [FRAME_W-1:0] COUNT_MAX       = 16'hFFFF;

   localparam logic [8*START_LEN-1:0] START_PAT = "@$Start$@";
   localparam logic [8*END_LEN-1:0]   END_PAT   = "$@End@$";

   // result kinds, also used as the queue op code
   localparam logic [1:0] KIND_DATA  = 2'd0;
   localparam logic [1:0] KIND_DONE  = 2'd1;
   localparam logic [1:0] KIND_ABORT = 2'd2;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = 2;

   typedef struct packed {
      logic [1:0]         kind;
      logic [7:0]         data;
      logic [TAG_W-1:0]   tag;
      logic [FRAME_W-1:0] len;
   } cmd_type;

   // Matcher steps. Neither marker has a proper border that can be reached
   // before a full match, so on a mismatch the only fallback is a fresh
   // first byte.
   function automatic logic [START_PROG_W-1:0] start_next(
      input logic [START_PROG_W-1:0] k,
      input logic [7:0]              c);
      logic [7:0] pat_b;
      logic       in_range;
      pat_b    = 8'h00;
      in_range = 1'b0;
      for (int i = 0; i < START_LEN; i++) begin
         if (k == START_PROG_W'(i)) begin
            pat_b    = START_PAT[8*(START_LEN-1-i) +: 8];
            in_range = 1'b1;
         end
      end
      if (in_range && pat_b == c)
         return k + 1'b1;
      else if (c == START_PAT[8*START_LEN-1 -: 8])
         return START_PROG_W'(1);
      else
         return '0;
   endfunction

   function automatic logic [END_PROG_W-1:0] end_next(
      input logic [END_PROG_W-1:0] k,
      input logic [7:0]            c);
      logic [7:0] pat_b;
      logic       in_range;
      pat_b    = 8'h00;
      in_range = 1'b0;
      for (int i = 0; i < END_LEN; i++) begin
         if (k == END_PROG_W'(i)) begin
            pat_b    = END_PAT[8*(END_LEN-1-i) +: 8];
            in_range = 1'b1;
         end
      end
      if (in_range && pat_b == c)
         return k + 1'b1;
      else if (c == END_PAT[8*END_LEN-1 -: 8])
         return END_PROG_W'(1);
      else
         return '0;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/mfd_front.sv =====
// ----------------------------------------------------------------------------
// mfd_front: byte classifier
// Runs both marker matchers, frame phase, tag decode and counters; issues
// one queue command per payload byte, frame completion or abandon.
// ----------------------------------------------------------------------------
`default_nettype none

module mfd_front #(
   parameter int TAG_DIGITS = mfd_pkg::TAG_DIGITS_DEFAULT
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_ready,
   input  wire logic [7:0]                   req_rx_byte,
   input  wire logic [mfd_pkg::FRAME_W-1:0]  max_frame,
   input  wire logic                         q_full,
   output logic                              q_push,
   output mfd_pkg::cmd_type                  q_cmd
);

   localparam int DCNT_W = (TAG_DIGITS < 2) ? 1 : $clog2(TAG_DIGITS + 1);
   localparam logic [DCNT_W-1:0] DIGITS_LAST = DCNT_W'(TAG_DIGITS);

   localparam logic [1:0] PH_HUNT    = 2'd0;
   localparam logic [1:0] PH_TAG     = 2'd1;
   localparam logic [1:0] PH_PAYLOAD = 2'd2;

   logic [1:0]                         phase_ff, phase_in;
   logic [mfd_pkg::START_PROG_W-1:0]   sprog_ff, sprog_in;
   logic [mfd_pkg::END_PROG_W-1:0]     eprog_ff, eprog_in;
   logic [DCNT_W-1:0]                  dcnt_ff, dcnt_in;
   logic                               stopped_ff, stopped_in;
   logic [mfd_pkg::TAG_W-1:0]          tag_ff, tag_in;
   logic [mfd_pkg::FILL_W-1:0]         fill_ff, fill_in;
   logic [mfd_pkg::FRAME_W-1:0]        frame_ff, frame_in;
   logic [mfd_pkg::FRAME_W-1:0]        pcount_ff, pcount_in;

   logic                               accept;
   logic [mfd_pkg::END_PROG_W-1:0]     e_next;
   logic [mfd_pkg::START_PROG_W-1:0]   s_next;
   logic                               end_hit;
   logic                               is_digit;

   assign req_ready = !q_full;
   assign accept    = req_valid && !q_full;
   assign e_next    = mfd_pkg::end_next(eprog_ff, req_rx_byte);
   assign s_next    = mfd_pkg::start_next(sprog_ff, req_rx_byte);
   assign end_hit   = (e_next == mfd_pkg::END_PROG_W'(mfd_pkg::END_LEN));
   assign is_digit  = (req_rx_byte >= 8'h30) && (req_rx_byte <= 8'h39);

   always_comb begin
      phase_in   = phase_ff;
      sprog_in   = sprog_ff;
      eprog_in   = eprog_ff;
      dcnt_in    = dcnt_ff;
      stopped_in = stopped_ff;
      tag_in     = tag_ff;
      fill_in    = fill_ff;
      frame_in   = frame_ff;
      pcount_in  = pcount_ff;
      q_push     = 1'b0;
      q_cmd      = '0;

      if (accept) begin
         eprog_in = end_hit ? '0 : e_next;
         if (phase_ff == PH_TAG || phase_ff == PH_PAYLOAD) begin
            frame_in = (frame_ff == mfd_pkg::COUNT_MAX) ? frame_ff : frame_ff + 1'b1;
            if (end_hit || frame_in >= max_frame) begin
               q_push   = 1'b1;
               phase_in = PH_HUNT;
               sprog_in = '0;
               fill_in  = '0;
               if (end_hit && phase_ff == PH_PAYLOAD &&
                   fill_ff >= mfd_pkg::FILL_W'(mfd_pkg::HOLD_DEPTH)) begin
                  q_cmd.kind = mfd_pkg::KIND_DONE;
                  q_cmd.tag  = tag_ff;
                  q_cmd.len  = pcount_ff;
               end else begin
                  q_cmd.kind = mfd_pkg::KIND_ABORT;
               end
            end else if (phase_ff == PH_TAG) begin
               if (!stopped_ff && is_digit)
                  tag_in = {tag_ff[mfd_pkg::TAG_W-4:0], 3'b000}
                         + {tag_ff[mfd_pkg::TAG_W-2:0], 1'b0}
                         + {{(mfd_pkg::TAG_W-4){1'b0}}, req_rx_byte[3:0]};
               else
                  stopped_in = 1'b1;
               dcnt_in = dcnt_ff + 1'b1;
               if (dcnt_in >= DIGITS_LAST) begin
                  phase_in  = PH_PAYLOAD;
                  fill_in   = '0;
                  pcount_in = '0;
               end
            end else begin
               q_push     = 1'b1;
               q_cmd.kind = mfd_pkg::KIND_DATA;
               q_cmd.data = req_rx_byte;
               if (fill_ff >= mfd_pkg::FILL_W'(mfd_pkg::HOLD_DEPTH)) begin
                  if (pcount_ff != mfd_pkg::COUNT_MAX)
                     pcount_in = pcount_ff + 1'b1;
               end else begin
                  fill_in = fill_ff + 1'b1;
               end
            end
         end else begin
            // hunting; the unused phase code lands here too
            phase_in = PH_HUNT;
            if (end_hit) begin
               sprog_in = '0;
            end else if (s_next == mfd_pkg::START_PROG_W'(mfd_pkg::START_LEN)) begin
               sprog_in   = '0;
               phase_in   = PH_TAG;
               dcnt_in    = '0;
               stopped_in = 1'b0;
               tag_in     = '0;
               fill_in    = '0;
               pcount_in  = '0;
               frame_in   = mfd_pkg::FRAME_W'(mfd_pkg::START_LEN);
               if (mfd_pkg::FRAME_W'(mfd_pkg::START_LEN) >= max_frame) begin
                  phase_in   = PH_HUNT;
                  q_push     = 1'b1;
                  q_cmd.kind = mfd_pkg::KIND_ABORT;
               end
            end else begin
               sprog_in = s_next;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_HUNT;
         sprog_ff   <= '0;
         eprog_ff   <= '0;
         dcnt_ff    <= '0;
         stopped_ff <= 1'b0;
         tag_ff     <= '0;
         fill_ff    <= '0;
         frame_ff   <= '0;
         pcount_ff  <= '0;
      end else begin
         phase_ff   <= phase_in;
         sprog_ff   <= sprog_in;
         eprog_ff   <= eprog_in;
         dcnt_ff    <= dcnt_in;
         stopped_ff <= stopped_in;
         tag_ff     <= tag_in;
         fill_ff    <= fill_in;
         frame_ff   <= frame_in;
         pcount_ff  <= pcount_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/mfd_fifo.sv =====
// ----------------------------------------------------------------------------
// mfd_fifo: command queue between classifier and output stage
// Small register-based FIFO of cmd_type entries.
// ----------------------------------------------------------------------------
`default_nettype none

module mfd_fifo (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire mfd_pkg::cmd_type wr_cmd,
   output logic                  full,
   input  wire logic             pop,
   output mfd_pkg::cmd_type      rd_cmd,
   output logic                  empty
);

   mfd_pkg::cmd_type              mem_ff [mfd_pkg::QUEUE_DEPTH];
   logic [mfd_pkg::QPTR_W-1:0]    wr_ptr_ff, rd_ptr_ff;
   logic [mfd_pkg::QPTR_W:0]      count_ff, count_in;

   assign full   = (count_ff == (mfd_pkg::QPTR_W+1)'(mfd_pkg::QUEUE_DEPTH));
   assign empty  = (count_ff == '0);
   assign rd_cmd = mem_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !pop)
         count_in = count_ff + 1'b1;
      else if (pop && !push)
         count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (push)
         mem_ff[wr_ptr_ff] <= wr_cmd;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push)
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (pop)
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         count_ff <= count_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/mfd_back.sv =====
// ----------------------------------------------------------------------------
// mfd_back: hold-back line and result register
// Executes queued commands: delays payload bytes by the hold-back depth and
// drives the result channel through a registered output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module mfd_back (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          q_empty,
   input  wire mfd_pkg::cmd_type              q_cmd,
   output logic                               q_pop,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic [1:0]                         rsp_kind,
   output logic [7:0]                         rsp_data_byte,
   output logic [mfd_pkg::TAG_W-1:0]          rsp_tag_value,
   output logic [mfd_pkg::FRAME_W-1:0]        rsp_payload_len
);

   logic [7:0]                    hb_ff [mfd_pkg::HOLD_DEPTH];
   logic [7:0]                    hb_in [mfd_pkg::HOLD_DEPTH];
   logic [mfd_pkg::FILL_W-1:0]    fill_ff, fill_in;
   logic                          valid_ff, valid_in;
   logic [1:0]                    kind_ff, kind_in;
   logic [7:0]                    data_ff, data_in;
   logic [mfd_pkg::TAG_W-1:0]     tag_ff, tag_in;
   logic [mfd_pkg::FRAME_W-1:0]   len_ff, len_in;

   assign q_pop           = !q_empty && (!valid_ff || rsp_ready);
   assign rsp_valid       = valid_ff;
   assign rsp_kind        = kind_ff;
   assign rsp_data_byte   = data_ff;
   assign rsp_tag_value   = tag_ff;
   assign rsp_payload_len = len_ff;

   always_comb begin
      hb_in    = hb_ff;
      fill_in  = fill_ff;
      valid_in = valid_ff && !rsp_ready;
      kind_in  = kind_ff;
      data_in  = data_ff;
      tag_in   = tag_ff;
      len_in   = len_ff;
      if (q_pop) begin
         unique case (q_cmd.kind)
            mfd_pkg::KIND_DATA: begin
               if (fill_ff >= mfd_pkg::FILL_W'(mfd_pkg::HOLD_DEPTH)) begin
                  valid_in = 1'b1;
                  kind_in  = mfd_pkg::KIND_DATA;
                  data_in  = hb_ff[0];
                  tag_in   = '0;
                  len_in   = '0;
                  for (int i = 0; i < mfd_pkg::HOLD_DEPTH - 1; i++)
                     hb_in[i] = hb_ff[i+1];
                  hb_in[mfd_pkg::HOLD_DEPTH-1] = q_cmd.data;
               end else begin
                  hb_in[fill_ff] = q_cmd.data;
                  fill_in        = fill_ff + 1'b1;
               end
            end
            mfd_pkg::KIND_DONE, mfd_pkg::KIND_ABORT: begin
               valid_in = 1'b1;
               kind_in  = q_cmd.kind;
               data_in  = q_cmd.data;
               tag_in   = q_cmd.tag;
               len_in   = q_cmd.len;
               fill_in  = '0;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      hb_ff   <= hb_in;
      kind_ff <= kind_in;
      data_ff <= data_in;
      tag_ff  <= tag_in;
      len_ff  <= len_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         fill_ff  <= fill_in;
         valid_ff <= valid_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/marker_frame_deframer.sv =====
// ----------------------------------------------------------------------------
// marker_frame_deframer: start/end marker frame extractor
// Usage:
//   req_* carries one received byte per transaction. rsp_* carries results:
//   kind 0 is a payload byte, 1 a completed frame (tag and payload length),
//   2 an abandoned frame. Not every byte yields a result.
//   csr_* writes max_frame (frame limit in bytes); write it only while idle.
// Throughput: one byte per cycle while the queue is not full; the output
//   stage retires one queued command per cycle while the result register is
//   free or rsp_ready is high. Path: a result is written to the queue at the
//   edge that accepts the byte causing it, then moves into the output
//   register. Payload bytes are held back until six further bytes arrive,
//   so end-marker bytes are never delivered.
// Reset: synchronous; returns to start hunting, empties the queue, sets
//   max_frame to 4096. No clearing pass.
// Stall: when rsp_ready is low the result register holds; the four-entry
//   queue absorbs further commands and req_ready drops once it is full.
// ----------------------------------------------------------------------------
`default_nettype none

module marker_frame_deframer #(
   parameter int TAG_DIGITS = mfd_pkg::TAG_DIGITS_DEFAULT
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic [7:0]                    req_rx_byte,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic [1:0]                         rsp_kind,
   output logic [7:0]                         rsp_data_byte,
   output logic [mfd_pkg::TAG_W-1:0]          rsp_tag_value,
   output logic [mfd_pkg::FRAME_W-1:0]        rsp_payload_len,
   input  wire logic                          csr_valid,
   output logic                               csr_ready,
   input  wire logic [mfd_pkg::FRAME_W-1:0]   csr_max_frame
);

   logic [mfd_pkg::FRAME_W-1:0]   max_frame_ff;
   logic                          q_full, q_empty, q_push, q_pop;
   mfd_pkg::cmd_type              push_cmd, pop_cmd;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset)
         max_frame_ff <= mfd_pkg::MAX_FRAME_RESET;
      else if (csr_valid)
         max_frame_ff <= csr_max_frame;
   end

   mfd_front #(
      .TAG_DIGITS (TAG_DIGITS)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_rx_byte (req_rx_byte),
      .max_frame   (max_frame_ff),
      .q_full      (q_full),
      .q_push      (q_push),
      .q_cmd       (push_cmd)
   );

   mfd_fifo u_fifo (
      .clock  (clock),
      .reset  (reset),
      .push   (q_push),
      .wr_cmd (push_cmd),
      .full   (q_full),
      .pop    (q_pop),
      .rd_cmd (pop_cmd),
      .empty  (q_empty)
   );

   mfd_back u_back (
      .clock           (clock),
      .reset           (reset),
      .q_empty         (q_empty),
      .q_cmd           (pop_cmd),
      .q_pop           (q_pop),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_kind        (rsp_kind),
      .rsp_data_byte   (rsp_data_byte),
      .rsp_tag_value   (rsp_tag_value),
      .rsp_payload_len (rsp_payload_len)
   );

endmodule

`default_nettype wire

// ===== rtl/mfd_checker.sv =====
// ----------------------------------------------------------------------------
// mfd_checker: port-level checks for the marker frame deframer
// Watches the result channel; attached to the top level by bind.
// ----------------------------------------------------------------------------
`default_nettype none

module mfd_checker (
   input wire logic                          clock,
   input wire logic                          reset,
   input wire logic                          rsp_valid,
   input wire logic                          rsp_ready,
   input wire logic [1:0]                    rsp_kind,
   input wire logic [7:0]                    rsp_data_byte,
   input wire logic [mfd_pkg::TAG_W-1:0]     rsp_tag_value,
   input wire logic [mfd_pkg::FRAME_W-1:0]   rsp_payload_len
);

   // stalled result transaction must hold
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_kind) &&
      $stable(rsp_data_byte) && $stable(rsp_tag_value) && $stable(rsp_payload_len))
      else $error("rsp transaction changed while stalled");

   a_kind_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_kind == mfd_pkg::KIND_DATA || rsp_kind == mfd_pkg::KIND_DONE ||
                    rsp_kind == mfd_pkg::KIND_ABORT)
      else $error("illegal result kind");

   a_data_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == mfd_pkg::KIND_DATA |->
      rsp_tag_value == '0 && rsp_payload_len == '0)
      else $error("payload byte carries frame fields");

   a_abort_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == mfd_pkg::KIND_ABORT |->
      rsp_tag_value == '0 && rsp_payload_len == '0 && rsp_data_byte == '0)
      else $error("abandon result carries nonzero fields");

   a_done_byte: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == mfd_pkg::KIND_DONE |-> rsp_data_byte == '0)
      else $error("frame complete carries a data byte");

endmodule

bind marker_frame_deframer mfd_checker u_mfd_checker (.*);

`default_nettype wire

// ===== bench/frame_result_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// frame_result_checker: result predictor and comparator for the deframer
// Watches the byte, result and limit-register channels, runs its own
// deframer model on every accepted byte and compares each accepted result,
// in order, against the oldest prediction.
// ----------------------------------------------------------------------------

module frame_result_checker (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   input  logic                        req_ready,
   input  logic [7:0]                  req_rx_byte,
   input  logic                        rsp_valid,
   input  logic                        rsp_ready,
   input  logic [1:0]                  rsp_kind,
   input  logic [7:0]                  rsp_data_byte,
   input  logic [mfd_pkg::TAG_W-1:0]   rsp_tag_value,
   input  logic [mfd_pkg::FRAME_W-1:0] rsp_payload_len,
   input  logic                        csr_valid,
   input  logic                        csr_ready,
   input  logic [mfd_pkg::FRAME_W-1:0] csr_max_frame,
   output int                          fail_count,
   output int                          expected_count
);

   localparam int TAG_W      = mfd_pkg::TAG_W;
   localparam int FRAME_W    = mfd_pkg::FRAME_W;
   localparam int START_LEN  = mfd_pkg::START_LEN;
   localparam int END_LEN    = mfd_pkg::END_LEN;
   localparam int HOLD_DEPTH = mfd_pkg::HOLD_DEPTH;
   localparam int PAT_W = 8 * START_LEN;
   localparam logic [PAT_W-1:0] START_BYTES = mfd_pkg::START_PAT;
   localparam logic [PAT_W-1:0] END_BYTES   = PAT_W'(mfd_pkg::END_PAT);
   localparam logic [7:0] ASCII_ZERO = 8'h30;
   localparam logic [7:0] ASCII_NINE = 8'h39;

   typedef enum logic [1:0] {HUNTING, IN_TAG, IN_PAYLOAD} frame_phase_type;

   typedef struct packed {
      logic [1:0]         kind;
      logic [7:0]         data_byte;
      logic [TAG_W-1:0]   tag_value;
      logic [FRAME_W-1:0] payload_len;
   } frame_result_type;

   frame_result_type   due_results[$];
   logic [FRAME_W-1:0] frame_limit;
   frame_phase_type    phase;
   int                 start_prog;
   int                 end_prog;
   int                 tag_chars;
   bit                 tag_done;
   logic [TAG_W-1:0]   tag_acc;
   logic [7:0]         hold_buf [0:HOLD_DEPTH-1];
   int                 held;
   logic [FRAME_W-1:0] frame_bytes;
   logic [FRAME_W-1:0] payload_bytes;

   function automatic logic [7:0] pat_byte(input logic [PAT_W-1:0] pat, input int len,
                                           input int idx);
      return pat[8*(len-1-idx) +: 8];
   endfunction

   // marker matcher with full fallback: longest prefix that is still a suffix
   function automatic int marker_step(input logic [PAT_W-1:0] pat, input int len,
                                      input int k, input logic [7:0] c);
      int  kk;
      bit  ok;
      kk = (k >= len) ? 0 : k;
      if (pat_byte(pat, len, kk) == c)
         return kk + 1;
      for (int j = kk; j >= 1; j--) begin
         ok = (pat_byte(pat, len, j-1) == c);
         for (int i = 0; ok && i + 1 < j; i++)
            if (pat_byte(pat, len, i) != pat_byte(pat, len, kk-j+1+i))
               ok = 1'b0;
         if (ok)
            return j;
      end
      return 0;
   endfunction

   task automatic queue_result(input logic [1:0] kind, input logic [7:0] data,
                               input logic [TAG_W-1:0] tag, input logic [FRAME_W-1:0] len);
      frame_result_type r;
      r.kind        = kind;
      r.data_byte   = data;
      r.tag_value   = tag;
      r.payload_len = len;
      due_results.push_back(r);
   endtask

   task automatic drop_frame();
      phase      = HUNTING;
      start_prog = 0;
      held       = 0;
      queue_result(mfd_pkg::KIND_ABORT, '0, '0, '0);
   endtask

   task automatic deframe_byte(input logic [7:0] c);
      int e;
      bit end_hit;
      e       = marker_step(END_BYTES, END_LEN, end_prog, c);
      end_hit = (e == END_LEN);
      end_prog = end_hit ? 0 : e;

      if (phase == IN_TAG || phase == IN_PAYLOAD) begin
         if (frame_bytes < mfd_pkg::COUNT_MAX)
            frame_bytes++;
         if (end_hit) begin
            // end marker only counts once all seven bytes sit behind the tag
            if (phase == IN_PAYLOAD && held >= HOLD_DEPTH) begin
               queue_result(mfd_pkg::KIND_DONE, '0, tag_acc, payload_bytes);
               phase      = HUNTING;
               start_prog = 0;
               held       = 0;
            end else begin
               drop_frame();
            end
         end else if (frame_bytes >= frame_limit) begin
            drop_frame();
         end else if (phase == IN_TAG) begin
            if (!tag_done && c >= ASCII_ZERO && c <= ASCII_NINE)
               tag_acc = tag_acc * 64'd10 + TAG_W'(c - ASCII_ZERO);
            else
               tag_done = 1'b1;
            tag_chars++;
            if (tag_chars >= mfd_pkg::TAG_DIGITS_DEFAULT) begin
               phase         = IN_PAYLOAD;
               held          = 0;
               payload_bytes = '0;
            end
         end else if (held >= HOLD_DEPTH) begin
            queue_result(mfd_pkg::KIND_DATA, hold_buf[0], '0, '0);
            for (int i = 0; i < HOLD_DEPTH - 1; i++)
               hold_buf[i] = hold_buf[i+1];
            hold_buf[HOLD_DEPTH-1] = c;
            if (payload_bytes < mfd_pkg::COUNT_MAX)
               payload_bytes++;
         end else begin
            hold_buf[held] = c;
            held++;
         end
      end else begin
         phase = HUNTING;
         if (end_hit) begin
            start_prog = 0;
         end else begin
            start_prog = marker_step(START_BYTES, START_LEN, start_prog, c);
            if (start_prog == START_LEN) begin
               start_prog    = 0;
               phase         = IN_TAG;
               tag_chars     = 0;
               tag_done      = 1'b0;
               tag_acc       = '0;
               held          = 0;
               payload_bytes = '0;
               frame_bytes   = FRAME_W'(START_LEN);
               if (frame_bytes >= frame_limit)
                  drop_frame();
            end
         end
      end
   endtask

   always @(posedge clock) begin
      frame_result_type want;
      if (reset) begin
         due_results.delete();
         frame_limit   = mfd_pkg::MAX_FRAME_RESET;
         phase         = HUNTING;
         start_prog    = 0;
         end_prog      = 0;
         tag_chars     = 0;
         tag_done      = 1'b0;
         tag_acc       = '0;
         held          = 0;
         frame_bytes   = '0;
         payload_bytes = '0;
         for (int i = 0; i < HOLD_DEPTH; i++)
            hold_buf[i] = '0;
         fail_count    = 0;
      end else begin
         // results pass the queue and output register, so compare before predicting
         if (rsp_valid && rsp_ready) begin
            if (due_results.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("unexpected result: kind %0d data %02h tag %0d len %0d",
                           rsp_kind, rsp_data_byte, rsp_tag_value, rsp_payload_len);
            end else begin
               want = due_results.pop_front();
               if (rsp_kind !== want.kind || rsp_data_byte !== want.data_byte ||
                   rsp_tag_value !== want.tag_value ||
                   rsp_payload_len !== want.payload_len) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display({"result mismatch: expected kind %0d data %02h tag %0d len %0d,",
                               " got kind %0d data %02h tag %0d len %0d"},
                              want.kind, want.data_byte, want.tag_value, want.payload_len,
                              rsp_kind, rsp_data_byte, rsp_tag_value, rsp_payload_len);
               end
            end
         end
         if (csr_valid && csr_ready)
            frame_limit = csr_max_frame;
         if (req_valid && req_ready)
            deframe_byte(req_rx_byte);
      end
      expected_count <= due_results.size();
   end

endmodule

// ===== bench/marker_frame_deframer_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// marker_frame_deframer_tb: stimulus and verdict for the marker deframer
// Feeds directed and random byte streams of framed, broken and noisy data
// across several frame limits, with bursty input and a stalling receiver;
// frame_result_checker does the prediction and comparison.
// ----------------------------------------------------------------------------

module marker_frame_deframer_tb;

   localparam int CYCLE_LIMIT = 400000;
   localparam int TAG_LEN     = mfd_pkg::TAG_DIGITS_DEFAULT;
   localparam int HOLD_CYCLES = 300;
   localparam int TAG_W       = mfd_pkg::TAG_W;
   localparam int FRAME_W     = mfd_pkg::FRAME_W;

   logic               clock;
   logic               reset           = 1'b1;
   logic               req_valid       = 1'b0;
   logic               req_ready;
   logic [7:0]         req_rx_byte     = '0;
   logic               rsp_valid;
   logic               rsp_ready       = 1'b0;
   logic [1:0]         rsp_kind;
   logic [7:0]         rsp_data_byte;
   logic [TAG_W-1:0]   rsp_tag_value;
   logic [FRAME_W-1:0] rsp_payload_len;
   logic               csr_valid       = 1'b0;
   logic               csr_ready;
   logic [FRAME_W-1:0] csr_max_frame   = '0;
   int                 fail_count;
   int                 expected_count;

   string      start_text = "@$Start$@";
   string      end_text   = "$@End@$";
   logic [7:0] stream_q[$];
   int         burst_left = 0;
   bit         steady     = 1'b0;
   bit         hold_rsp   = 1'b0;

   marker_frame_deframer dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_rx_byte     (req_rx_byte),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_kind        (rsp_kind),
      .rsp_data_byte   (rsp_data_byte),
      .rsp_tag_value   (rsp_tag_value),
      .rsp_payload_len (rsp_payload_len),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_max_frame   (csr_max_frame)
   );

   frame_result_checker result_check (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_rx_byte     (req_rx_byte),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_kind        (rsp_kind),
      .rsp_data_byte   (rsp_data_byte),
      .rsp_tag_value   (rsp_tag_value),
      .rsp_payload_len (rsp_payload_len),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_max_frame   (csr_max_frame),
      .fail_count      (fail_count),
      .expected_count  (expected_count)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      int cycles;
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("Test completed with failures");
      $finish;
   end

   // receiver: random ready duty cycle per stretch, plus long hold-offs on request
   initial begin
      int ready_pct;
      int left;
      ready_pct = 100;
      left      = 0;
      forever begin
         @(posedge clock);
         if (hold_rsp) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_rsp = 1'b0;
         end
         if (left == 0) begin
            left = $urandom_range(16, 80);
            case ($urandom_range(0, 3))
               0: ready_pct = 100;
               1: ready_pct = 75;
               2: ready_pct = 40;
               default: ready_pct = 15;
            endcase
         end
         left--;
         rsp_ready <= ($urandom_range(1, 100) <= ready_pct);
      end
   end

   // one byte transaction; unless steady, random-length bursts with random gaps
   task automatic put_byte(input logic [7:0] b);
      int gap;
      if (!steady && burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         gap        = $urandom_range(0, 4);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      if (burst_left > 0)
         burst_left--;
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic flush_stream();
      while (stream_q.size() > 0)
         put_byte(stream_q.pop_front());
   endtask

   task automatic push_text(input string s);
      for (int i = 0; i < s.len(); i++)
         stream_q.push_back(s[i]);
   endtask

   task automatic push_digits(input int n);
      repeat (n) stream_q.push_back(8'(8'h30 + $urandom_range(0, 9)));
   endtask

   task automatic push_payload(input int n);
      repeat (n) stream_q.push_back(8'($urandom_range(0, 255)));
   endtask

   // mode 0: random digits, 1: a non-digit somewhere, 2: all nines
   task automatic push_tag(input int mode);
      int         cut;
      logic [7:0] b;
      cut = (mode == 1) ? $urandom_range(0, TAG_LEN - 1) : TAG_LEN;
      for (int i = 0; i < TAG_LEN; i++) begin
         if (mode == 2) begin
            stream_q.push_back(8'h39);
         end else if (i == cut) begin
            b = 8'($urandom_range(0, 255));
            if (b >= 8'h30 && b <= 8'h39)
               b = b + 8'h10;
            stream_q.push_back(b);
         end else begin
            stream_q.push_back(8'(8'h30 + $urandom_range(0, 9)));
         end
      end
   endtask

   task automatic push_random_frame();
      int shape;
      int cut;
      shape = $urandom_range(0, 99);
      push_payload($urandom_range(0, 4));
      if (shape < 6) begin
         // start marker cut short
         cut = $urandom_range(1, mfd_pkg::START_LEN - 1);
         for (int i = 0; i < cut; i++)
            stream_q.push_back(start_text[i]);
         push_payload($urandom_range(0, 3));
      end else begin
         push_text(start_text);
         if (shape < 12) begin
            push_digits($urandom_range(0, TAG_LEN - 1));
            push_text(end_text);
         end else if (shape < 18) begin
            // end marker straddles the end of the tag or begins right after it
            push_digits(TAG_LEN - $urandom_range(0, mfd_pkg::HOLD_DEPTH));
            push_text(end_text);
         end else begin
            push_tag((shape < 30) ? 1 : (shape < 34) ? 2 : 0);
            push_payload(($urandom_range(0, 9) == 0) ? $urandom_range(13, 70)
                                                     : $urandom_range(0, 12));
            // occasionally no end marker: the frame runs into the next one
            if (shape < 95)
               push_text(end_text);
         end
      end
   endtask

   task automatic random_frames(input int n);
      steady = ($urandom_range(0, 2) == 0);
      repeat (n) begin
         push_random_frame();
         flush_stream();
      end
      steady = 1'b0;
   endtask

   // stop sending until every predicted result is back, then let the pipe empty
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_count != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_limit(input logic [FRAME_W-1:0] v);
      csr_valid     <= 1'b1;
      csr_max_frame <= v;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed streams at the reset frame limit
      stream_q.push_back(8'h00);
      stream_q.push_back(8'hFF);
      push_text("@$Sta$@End@$t$@");
      push_text("@@$Sta@$Start$@00000000000000000042hello");
      push_text(end_text);
      push_text({start_text, "99999999999999999999", end_text});
      push_text({start_text, "18446744073709551615"});
      stream_q.push_back(8'h00);
      stream_q.push_back(8'hFF);
      push_text(end_text);
      push_text({start_text, "123x4567890123456789$@Enx", end_text});
      push_text({start_text, "1234567", end_text});
      push_text({start_text, "12345678901234567$@End@$"});
      push_text({end_text, start_text, "00000000000000000000", start_text, end_text});
      flush_stream();
      settle();

      // tightest limit: only a bare frame fits
      write_limit(FRAME_W'(36));
      push_text({start_text, "00000000000000000007", end_text});
      push_text({start_text, "00000000000000000007A", end_text});
      flush_stream();
      settle();

      // widest limit, with a long receiver hold-off under a long payload
      write_limit(mfd_pkg::COUNT_MAX);
      hold_rsp = 1'b1;
      steady   = 1'b1;
      push_text(start_text);
      push_tag(0);
      push_payload(24);
      push_text(end_text);
      flush_stream();
      steady = 1'b0;
      settle();

      write_limit(FRAME_W'(57));
      random_frames(1);
      settle();

      write_limit(mfd_pkg::MAX_FRAME_RESET);
      random_frames(1);
      settle();
      repeat (8) @(posedge clock);

      if (fail_count == 0 && expected_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
